[hdl/swed_pkg.sv]
// Shared package for the square window erosion and dilation core.
// Holds default sizes, register codes, reset values and the stage control record.
// No dependencies.
package swed_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 7;
  localparam int DEF_PIXEL_BITS = 16;

  // Largest frame height the height register can express.
  localparam int MAX_HEIGHT = 4095;

  // Configuration port and register field widths.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_W_BITS     = 11;
  localparam int CFG_H_BITS     = 12;
  localparam int CFG_R_BITS     = 3;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_WINDOW_RADIUS  = 2'd2,
    REG_OPERATION_MODE = 2'd3
  } reg_index_t;

  // Register reset values.
  localparam logic [CFG_W_BITS-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [CFG_R_BITS-1:0] RST_RADIUS       = 3'd1;
  localparam logic                  RST_MODE         = 1'b0;

  // Request kinds and operation modes.
  localparam logic ACT_PIXEL   = 1'b0;
  localparam logic ACT_FLUSH   = 1'b1;
  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  // Control record that travels with each request through the stages.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic mode;
  } swed_ctl_t;

endpackage

[hdl/swed_ram.sv]
// Generic single-port RAM with registered read data, read-before-write.
// Used as one line store per cell. No dependencies.
module swed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // Old contents are returned when the same address is written.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/swed_cell.sv]
// One cell of the vertical chain: a line store that delays pixels by one row,
// and a stage that folds the current row value into the column extreme.
// Depends on swed_pkg and swed_ram.
module swed_cell import swed_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int DEPTH      = 1024,
  parameter int MASK_BITS  = 15,
  parameter int IDX        = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  swed_ctl_t                             in_ctl,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] in_col,
  input  logic [PIXEL_BITS-1:0]                 in_acc,
  input  logic [PIXEL_BITS-1:0]                 in_val,
  input  logic [MASK_BITS-1:0]                  in_incl,
  input  logic [MASK_BITS-1:0]                  in_hmask,
  output swed_ctl_t                             out_ctl,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] out_col,
  output logic [PIXEL_BITS-1:0]                 out_acc,
  output logic [PIXEL_BITS-1:0]                 out_val,
  output logic [MASK_BITS-1:0]                  out_incl,
  output logic [MASK_BITS-1:0]                  out_hmask
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [PIXEL_BITS-1:0] pick(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b,
                                                 input logic                  mode);
    if (mode == MODE_DILATE) begin
      return (a > b) ? a : b;
    end else begin
      return (a < b) ? a : b;
    end
  endfunction

  swed_ctl_t             ctl_r;
  logic [AW-1:0]         col_r;
  logic [PIXEL_BITS-1:0] acc_r;
  logic [PIXEL_BITS-1:0] acc_nxt;
  logic [MASK_BITS-1:0]  incl_r;
  logic [MASK_BITS-1:0]  hmask_r;
  logic                  ram_en;

  // Fold this row into the extreme when the row lies inside the frame.
  always_comb begin
    acc_nxt = in_incl[IDX] ? pick(in_acc, in_val, in_ctl.mode) : in_acc;
  end

  // Control advances with the whole pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= in_ctl;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      col_r   <= in_col;
      acc_r   <= acc_nxt;
      incl_r  <= in_incl;
      hmask_r <= in_hmask;
    end
  end

  // The line store gives the pixel one row above and keeps the current one.
  assign ram_en = adv && in_ctl.valid;

  swed_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_en),
    .addr  (in_col),
    .wdata (in_val),
    .rdata (out_val)
  );

  assign out_ctl   = ctl_r;
  assign out_col   = col_r;
  assign out_acc   = acc_r;
  assign out_incl  = incl_r;
  assign out_hmask = hmask_r;

endmodule

[hdl/swed_hwin.sv]
// Horizontal stage: keeps the last column extremes and reduces the window
// through a registered compare tree. Depends on swed_pkg.
module swed_hwin import swed_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int MASK_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  swed_ctl_t             in_ctl,
  input  logic [PIXEL_BITS-1:0] in_acc,
  input  logic [PIXEL_BITS-1:0] in_val,
  input  logic                  in_incl,
  input  logic [MASK_BITS-1:0]  in_hmask,
  output swed_ctl_t             out_ctl,
  output logic [PIXEL_BITS-1:0] out_result
);

  localparam int NT = MASK_BITS - 1;
  localparam int TL = $clog2(MASK_BITS);
  localparam int NP = 1 << TL;

  function automatic logic [PIXEL_BITS-1:0] pick(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b,
                                                 input logic                  mode);
    if (mode == MODE_DILATE) begin
      return (a > b) ? a : b;
    end else begin
      return (a < b) ? a : b;
    end
  endfunction

  logic [PIXEL_BITS-1:0] col_ext;
  logic [PIXEL_BITS-1:0] ident;
  logic [PIXEL_BITS-1:0] taps_r [0:NT-1];
  logic [PIXEL_BITS-1:0] leaf   [0:NP-1];
  logic [PIXEL_BITS-1:0] node_r [0:NP-2];
  swed_ctl_t             meta_r [0:TL-1];

  // Last row of the column, then the window leaves with masked columns neutral.
  always_comb begin
    col_ext = in_incl ? pick(in_acc, in_val, in_ctl.mode) : in_acc;
    ident   = (in_ctl.mode == MODE_DILATE) ? '0 : '1;
    for (int k = 0; k < NP; k++) begin
      if (k == 0) begin
        leaf[k] = in_hmask[0] ? col_ext : ident;
      end else if (k < MASK_BITS) begin
        leaf[k] = in_hmask[k] ? taps_r[k-1] : ident;
      end else begin
        leaf[k] = ident;
      end
    end
  end

  // Column extremes shift once per request.
  always_ff @(posedge clk) begin
    if (adv && in_ctl.valid) begin
      taps_r[0] <= col_ext;
      for (int k = 1; k < NT; k++) begin
        taps_r[k] <= taps_r[k-1];
      end
    end
  end

  // Control follows the tree one level per cycle while the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < TL; l++) begin
        meta_r[l] <= '0;
      end
    end else if (adv) begin
      meta_r[0] <= in_ctl;
      for (int l = 1; l < TL; l++) begin
        meta_r[l] <= meta_r[l-1];
      end
    end
  end

  // Registered compare tree, deepest level fed from the leaves.
  for (genvar dd = 0; dd < TL; dd++) begin : g_depth
    for (genvar j = 0; j < (1 << dd); j++) begin : g_node
      localparam int NI = (1 << dd) - 1 + j;
      if (dd == TL - 1) begin : g_leaf
        always_ff @(posedge clk) begin
          if (adv) begin
            node_r[NI] <= pick(leaf[2*j], leaf[2*j+1], in_ctl.mode);
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          if (adv) begin
            node_r[NI] <= pick(node_r[2*NI+1], node_r[2*NI+2], meta_r[TL-2-dd].mode);
          end
        end
      end
    end
  end

  assign out_ctl    = meta_r[TL-1];
  assign out_result = node_r[0];

endmodule

[hdl/square_window_erode_dilate_core.sv]
// Square window grey-level erosion or dilation over a raster pixel stream.
// Usage: requests enter on in_valid/in_stall, each a pixel or a flush request.
// After the frame's pixels the source sends radius*width+radius flush requests;
// the result for pixel o leaves with request o+radius*width+radius, and the
// final result of the frame carries out_frame_last. Flushes before the frame's
// pixels are complete are taken and dropped; late pixels count as flushes.
// Geometry and mode are written on the cfg port and are taken up at the first
// request of each frame. The window is clipped at the frame borders.
// Throughput is one request per cycle while the pipeline is not frozen. On its
// way a request passes the front register, one register per line-store cell
// of the vertical chain, one per level of the horizontal compare tree, and
// the output register.
// While out_stall holds a waiting result, the whole pipeline freezes and
// in_stall is raised; otherwise requests are taken while a result waits.
// Reset (rst_n low, synchronous) empties the pipeline, clears the frame
// counters and restores the register defaults; the line stores are not cleared.
// Depends on swed_pkg, swed_cell, swed_hwin and swed_ram.
module square_window_erode_dilate_core import swed_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic [PIXEL_BITS-1:0]     in_pixel_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIXEL_BITS-1:0]     out_result_value,
  output logic                      out_frame_last,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_RADIUS + 1);
  localparam int YW = $clog2(MAX_HEIGHT + MAX_RADIUS + 2);
  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * (MAX_WIDTH + 1) + 1);
  localparam int NC = 2 * MAX_RADIUS;
  localparam int NM = NC + 1;

  // Configuration registers.
  logic [CFG_W_BITS-1:0] cfg_w_r;
  logic [CFG_H_BITS-1:0] cfg_h_r;
  logic [CFG_R_BITS-1:0] cfg_r_r;
  logic                  cfg_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= RST_FRAME_WIDTH;
      cfg_h_r    <= RST_FRAME_HEIGHT;
      cfg_r_r    <= RST_RADIUS;
      cfg_mode_r <= RST_MODE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    cfg_w_r    <= cfg_data[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT:   cfg_h_r    <= cfg_data[CFG_H_BITS-1:0];
        REG_WINDOW_RADIUS:  cfg_r_r    <= cfg_data[CFG_R_BITS-1:0];
        REG_OPERATION_MODE: cfg_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamped geometry and the frame's request counts.
  logic [WW-1:0]         w_s;
  logic [CFG_H_BITS-1:0] h_s;
  logic [RW-1:0]         r_s;
  logic [CW-1:0]         tot_s;
  logic [CW-1:0]         delay_s;
  logic [CW-1:0]         lastpos_s;

  always_comb begin
    if (cfg_w_r == '0) begin
      w_s = WW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_s = WW'(MAX_WIDTH);
    end else begin
      w_s = WW'(cfg_w_r);
    end
    h_s = (cfg_h_r == '0) ? CFG_H_BITS'(1) : cfg_h_r;
    r_s = (32'(cfg_r_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_r_r);
    tot_s     = CW'(w_s) * CW'(h_s);
    delay_s   = CW'(r_s) * CW'(w_s) + CW'(r_s);
    lastpos_s = delay_s + tot_s - CW'(1);
  end

  // Frame settings held from the first request of the frame.
  logic [WW-1:0]         lat_w_r;
  logic [CFG_H_BITS-1:0] lat_h_r;
  logic [RW-1:0]         lat_r_r;
  logic                  lat_mode_r;
  logic [CW-1:0]         lat_total_r;
  logic [CW-1:0]         lat_delay_r;
  logic [CW-1:0]         lat_lastpos_r;

  // Frame position counters.
  logic [CW-1:0] cnt_r;
  logic [XW-1:0] pos_col_r;
  logic [YW-1:0] pos_row_r;
  logic [XW-1:0] out_x_r;

  // Output register state.
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_value_r;
  logic                  out_last_r;

  logic                  adv;
  logic                  in_take;
  logic                  first;
  logic [WW-1:0]         cur_w;
  logic [CFG_H_BITS-1:0] cur_h;
  logic [RW-1:0]         cur_r;
  logic                  cur_mode;
  logic                  in_phase;
  logic                  proc;
  logic                  emit_c;
  logic                  last_c;
  logic [NM-1:0]         incl_c;
  logic [NM-1:0]         hmask_c;

  assign adv     = !out_valid_r || !out_stall;
  assign in_take = in_valid && adv;
  assign in_stall = !adv;

  // Classify the request and build the row and column masks of its window.
  always_comb begin
    first    = (cnt_r == '0);
    cur_w    = first ? w_s : lat_w_r;
    cur_h    = first ? h_s : lat_h_r;
    cur_r    = first ? r_s : lat_r_r;
    cur_mode = first ? cfg_mode_r : lat_mode_r;
    in_phase = first || (cnt_r < lat_total_r);
    proc     = !(in_phase && (in_action == ACT_FLUSH));
    if (first) begin
      emit_c = (r_s == '0);
      last_c = emit_c && (w_s == WW'(1)) && (h_s == CFG_H_BITS'(1));
    end else begin
      emit_c = (cnt_r >= lat_delay_r) && (cnt_r <= lat_lastpos_r);
      last_c = emit_c && (cnt_r == lat_lastpos_r);
    end
    for (int d = 0; d < NM; d++) begin
      incl_c[d] = (d <= 2 * int'(cur_r)) && (d <= int'(pos_row_r)) &&
                  (int'(pos_row_r) <= int'(cur_h) - 1 + d);
      hmask_c[d] = (d <= int'(out_x_r) + int'(cur_r)) &&
                   (d + int'(cur_w) - 1 >= int'(out_x_r) + int'(cur_r)) &&
                   (d <= 2 * int'(cur_r));
    end
  end

  // Counters move on every request that is not dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      pos_col_r <= '0;
      pos_row_r <= '0;
      out_x_r   <= '0;
    end else if (in_take && proc) begin
      if (last_c) begin
        cnt_r     <= '0;
        pos_col_r <= '0;
        pos_row_r <= '0;
        out_x_r   <= '0;
      end else begin
        cnt_r <= cnt_r + CW'(1);
        if (WW'(pos_col_r) + WW'(1) == cur_w) begin
          pos_col_r <= '0;
          pos_row_r <= pos_row_r + YW'(1);
        end else begin
          pos_col_r <= pos_col_r + XW'(1);
        end
        if (emit_c) begin
          if (WW'(out_x_r) + WW'(1) == cur_w) begin
            out_x_r <= '0;
          end else begin
            out_x_r <= out_x_r + XW'(1);
          end
        end
      end
    end
  end

  // Take up the frame settings at its first request.
  always_ff @(posedge clk) begin
    if (in_take && first) begin
      lat_w_r       <= w_s;
      lat_h_r       <= h_s;
      lat_r_r       <= r_s;
      lat_mode_r    <= cfg_mode_r;
      lat_total_r   <= tot_s;
      lat_delay_r   <= delay_s;
      lat_lastpos_r <= lastpos_s;
    end
  end

  // Front register that feeds the first cell.
  swed_ctl_t             st_ctl_r;
  swed_ctl_t             st_ctl_nxt;
  logic [XW-1:0]         st_col_r;
  logic [PIXEL_BITS-1:0] st_pix_r;
  logic [NM-1:0]         st_incl_r;
  logic [NM-1:0]         st_hmask_r;

  always_comb begin
    st_ctl_nxt.valid = in_valid && proc;
    st_ctl_nxt.emit  = emit_c;
    st_ctl_nxt.last  = last_c;
    st_ctl_nxt.mode  = cur_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_ctl_r <= '0;
    end else if (adv) begin
      st_ctl_r <= st_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_col_r   <= pos_col_r;
      st_pix_r   <= in_pixel_value;
      st_incl_r  <= incl_c;
      st_hmask_r <= hmask_c;
    end
  end

  // Vertical chain of line-store cells.
  swed_ctl_t             ch_ctl   [0:NC];
  logic [XW-1:0]         ch_col   [0:NC];
  logic [PIXEL_BITS-1:0] ch_acc   [0:NC];
  logic [PIXEL_BITS-1:0] ch_val   [0:NC];
  logic [NM-1:0]         ch_incl  [0:NC];
  logic [NM-1:0]         ch_hmask [0:NC];

  assign ch_ctl[0]   = st_ctl_r;
  assign ch_col[0]   = st_col_r;
  assign ch_acc[0]   = (st_ctl_r.mode == MODE_DILATE) ? '0 : '1;
  assign ch_val[0]   = st_pix_r;
  assign ch_incl[0]  = st_incl_r;
  assign ch_hmask[0] = st_hmask_r;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    swed_cell #(
      .PIXEL_BITS (PIXEL_BITS),
      .DEPTH      (MAX_WIDTH),
      .MASK_BITS  (NM),
      .IDX        (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_ctl    (ch_ctl[k]),
      .in_col    (ch_col[k]),
      .in_acc    (ch_acc[k]),
      .in_val    (ch_val[k]),
      .in_incl   (ch_incl[k]),
      .in_hmask  (ch_hmask[k]),
      .out_ctl   (ch_ctl[k+1]),
      .out_col   (ch_col[k+1]),
      .out_acc   (ch_acc[k+1]),
      .out_val   (ch_val[k+1]),
      .out_incl  (ch_incl[k+1]),
      .out_hmask (ch_hmask[k+1])
    );
  end

  // Horizontal window over the column extremes.
  swed_ctl_t             hw_ctl;
  logic [PIXEL_BITS-1:0] hw_result;

  swed_hwin #(
    .PIXEL_BITS (PIXEL_BITS),
    .MASK_BITS  (NM)
  ) u_hwin (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_ctl     (ch_ctl[NC]),
    .in_acc     (ch_acc[NC]),
    .in_val     (ch_val[NC]),
    .in_incl    (ch_incl[NC][NC]),
    .in_hmask   (ch_hmask[NC]),
    .out_ctl    (hw_ctl),
    .out_result (hw_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= hw_ctl.valid && hw_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_value_r <= hw_result;
      out_last_r  <= hw_ctl.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_frame_last   = out_last_r;

endmodule

[bench/testbench.sv]
// Self-checking bench for square_window_erode_dilate_core: streamed frames in both modes.
// A scoreboard class predicts each clipped window extreme; plain tasks drive the block.
// Depends on swed_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import swed_pkg::*;

  localparam int ROW_SLOTS = 3 * DEF_MAX_RADIUS + 2;
  localparam int LATENCY   = 40;
  localparam int LIMIT     = 2000000;

  typedef struct {
    logic [15:0] value;
    logic        last;
  } window_result_t;

  // Predicts the window minimum or maximum for every request and checks results in order.
  class window_scoreboard;
    int unsigned reg_w, reg_h, reg_r, reg_mode;
    int unsigned lat_w, lat_h, lat_r, lat_mode;
    int unsigned req_count, col, row;
    logic [15:0] lines [ROW_SLOTS * DEF_MAX_WIDTH];
    window_result_t expected_pixels [$];
    int errors, checked;

    function new();
      reg_w = RST_FRAME_WIDTH;
      reg_h = RST_FRAME_HEIGHT;
      reg_r = RST_RADIUS;
      reg_mode = RST_MODE;
      req_count = 0;
      col = 0;
      row = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:    reg_w = data[CFG_W_BITS-1:0];
        REG_FRAME_HEIGHT:   reg_h = data[CFG_H_BITS-1:0];
        REG_WINDOW_RADIUS:  reg_r = data[CFG_R_BITS-1:0];
        REG_OPERATION_MODE: reg_mode = data[0];
        default: ;
      endcase
    endfunction

    function logic [15:0] extreme_at(int unsigned x, int unsigned y);
      int unsigned y0, y1, x0, x1;
      logic [15:0] acc, v;
      y0 = (y >= lat_r) ? y - lat_r : 0;
      y1 = (y + lat_r < lat_h) ? y + lat_r : lat_h - 1;
      x0 = (x >= lat_r) ? x - lat_r : 0;
      x1 = (x + lat_r < lat_w) ? x + lat_r : lat_w - 1;
      acc = (lat_mode == MODE_DILATE) ? 16'h0000 : 16'hFFFF;
      for (int unsigned cy = y0; cy <= y1; cy++) begin
        for (int unsigned cx = x0; cx <= x1; cx++) begin
          v = lines[(cy % ROW_SLOTS) * DEF_MAX_WIDTH + cx];
          if ((lat_mode == MODE_DILATE) ? (v > acc) : (v < acc)) acc = v;
        end
      end
      return acc;
    endfunction

    function void note_request(logic act, logic [15:0] pix);
      int unsigned total, delay, n, o;
      window_result_t res;
      // Geometry and mode are taken up at the first request of a frame.
      if (req_count == 0) begin
        lat_w = (reg_w == 0) ? 1 : ((reg_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : reg_w);
        lat_h = (reg_h == 0) ? 1 : reg_h;
        lat_r = (reg_r > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : reg_r;
        lat_mode = reg_mode;
      end
      total = lat_w * lat_h;
      delay = lat_r * lat_w + lat_r;
      // A flush during the pixel phase is dropped; a late pixel counts as a flush.
      if (req_count < total) begin
        if (act == ACT_FLUSH) return;
        lines[(row % ROW_SLOTS) * DEF_MAX_WIDTH + col] = pix;
        col++;
        if (col >= lat_w) begin
          col = 0;
          row++;
        end
      end
      n = req_count;
      req_count++;
      if (n < delay) return;
      o = n - delay;
      if (o >= total) return;
      res.value = extreme_at(o % lat_w, o / lat_w);
      res.last = (o == total - 1);
      expected_pixels.push_back(res);
      if (res.last) begin
        req_count = 0;
        col = 0;
        row = 0;
      end
    endfunction

    function void check_result(logic [15:0] value, logic last);
      window_result_t exp_res;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: result_value %0h frame_last %0b", value, last);
        errors++;
        return;
      end
      exp_res = expected_pixels.pop_front();
      checked++;
      if (value !== exp_res.value) begin
        $error("result_value: expected %0h, actual %0h", exp_res.value, value);
        errors++;
      end
      if (last !== exp_res.last) begin
        $error("frame_last: expected %0b, actual %0b", exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACT_PIXEL;
  logic [15:0] in_pixel_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_result_value;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  window_scoreboard board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;
  int requests_sent = 0;
  int frames_done = 0;
  logic in_take = 1'b0, out_take = 1'b0;
  logic act_s, last_s;
  logic [15:0] pix_s, res_s;

  square_window_erode_dilate_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Handshakes are sampled mid-cycle so that nothing depends on event order at the edge.
  always @(negedge clk) begin
    in_take = rst_n && in_valid && !in_stall;
    act_s = in_action;
    pix_s = in_pixel_value;
    out_take = rst_n && out_valid && !out_stall;
    res_s = out_result_value;
    last_s = out_frame_last;
  end

  always @(posedge clk) begin
    if (in_take) board.note_request(act_s, pix_s);
    if (out_take) board.check_result(res_s, last_s);
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic act, logic [15:0] pix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_pixel_value <= pix;
    do @(posedge clk); while (!in_take);
    requests_sent++;
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles; upper data bits may carry junk.
  task automatic write_setup(int w, int h, int r, int mode);
    logic [CFG_DATA_BITS-1:0] vals [4];
    vals[0] = {1'($urandom_range(1)), w[CFG_W_BITS-1:0]};
    vals[1] = h[CFG_H_BITS-1:0];
    vals[2] = {9'($urandom_range(511)), r[CFG_R_BITS-1:0]};
    vals[3] = {11'($urandom_range(2047)), mode[0]};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data <= vals[i];
      board.write_reg(reg_index_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // One frame: pixels, then the drain flushes; noise adds stray flushes and late pixels.
  task automatic run_frame(int w, int h, int r, int mode, int noise_pct, bit pause_mid);
    int ew, eh, delay;
    ew = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
    eh = (h == 0) ? 1 : h;
    delay = r * ew + r;
    case (frames_done % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 53; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 53; end
      default: begin send_idle_pct = 30; stall_pct = 30; end
    endcase
    write_setup(w, h, r, mode);
    for (int i = 0; i < ew * eh; i++) begin
      if ($urandom_range(99) < noise_pct)
        send_request(ACT_FLUSH, 16'($urandom_range(16'hFFFF)));
      send_request(ACT_PIXEL, pick_pixel());
      if (pause_mid && i == (ew * eh) / 2) begin
        in_valid <= 1'b0;
        while (board.expected_pixels.size() != 0) @(posedge clk);
      end
    end
    for (int i = 0; i < delay; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(ACT_PIXEL, pick_pixel());
      else send_request(ACT_FLUSH, 16'($urandom_range(16'hFFFF)));
    end
    go_quiet();
    frames_done++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed frames: single pixel, oversized radius, both modes, border and size extremes.
    run_frame(1, 1, 0, MODE_ERODE, 0, 0);
    run_frame(1, 1, 7, MODE_DILATE, 0, 0);
    run_frame(0, 0, 3, MODE_ERODE, 0, 0);
    run_frame(3, 2, 7, MODE_DILATE, 30, 0);
    run_frame(4, 3, 1, MODE_ERODE, 40, 0);
    run_frame(2047, 1, 0, MODE_DILATE, 0, 0);
    run_frame(1, 200, 7, MODE_DILATE, 0, 0);
    // Long receiver hold-off while the sender keeps offering.
    hold_cycles = 400;
    run_frame(16, 6, 2, MODE_ERODE, 5, 0);
    run_frame(9, 7, 2, MODE_DILATE, 5, 1);
    // Random frames, mostly well formed with some stray and late requests.
    while (requests_sent < 1850) begin
      int w, h;
      w = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 12);
      h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      run_frame(w, h, $urandom_range(7), $urandom_range(1),
                ($urandom_range(3) == 0) ? 10 : 0, $urandom_range(15) == 0);
    end
    $display("Covered %0d frames, %0d requests, %0d results checked in both modes.",
             frames_done, requests_sent, board.checked);
    if (board.errors == 0 && board.expected_pixels.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
